@@ hw/rtl/mcgt_pkg.sv @@
// Multicast group member table: shared types and command codes.
// No dependencies; used by the top level and the checker by scoped names.
package mcgt_pkg;

  localparam int ADDR_W   = 32;
  localparam int BITMAP_W = 16;

  localparam logic [1:0] CMD_JOIN  = 2'd0;
  localparam logic [1:0] CMD_LEAVE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [3:0]        port;
    logic [ADDR_W-1:0] group_addr;
  } in_t;

  typedef struct packed {
    logic [BITMAP_W-1:0] member_bitmap;
    logic                hit;
    logic                full_drop;
  } out_t;

endpackage

@@ hw/rtl/mcgt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mcgt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/multicast_group_member_table_top.sv @@
// Multicast group member table top level: scan/update sequencer and two RAMs.
// Depends on mcgt_pkg and mcgt_ram.

// One command at a time: busy rises after start is taken and falls in the
// cycle the result strobes on done. The used entries are scanned from index
// 0, one RAM read per cycle, and the scan stops at the first match or at the
// fill count. A new command may be started in the cycle the result is
// shown. The result is valid for exactly one cycle and cannot be held off.
// No clearing pass after reset: only entries below the fill count are ever
// used.
module multicast_group_member_table_top #(
  parameter int MAX_GROUPS = 64,
  parameter int PORT_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mcgt_pkg::in_t req,
  output logic          done,
  output mcgt_pkg::out_t result
);

  localparam int AW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW    = $clog2(MAX_GROUPS + 1);
  localparam int EXT_W = (PORT_BITS > mcgt_pkg::BITMAP_W) ? PORT_BITS : mcgt_pkg::BITMAP_W;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t              state;
  mcgt_pkg::in_t       req_q;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       idx;
  logic [AW-1:0]       pidx;
  logic                pend;

  logic [mcgt_pkg::ADDR_W-1:0] addr_rd;
  logic [PORT_BITS-1:0]        mem_rd;
  logic [PORT_BITS-1:0]        pbit;
  logic [PORT_BITS-1:0]        upd;
  logic                        match;
  logic                        at_end;
  logic                        hit_now;
  logic                        miss_now;
  logic                        room;
  logic                        app;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [PORT_BITS-1:0]        mem_wdata;
  logic [EXT_W-1:0]            upd_ext;
  logic [EXT_W-1:0]            pbit_ext;

  always_comb begin
    pbit = '0;
    if (32'(req_q.port) < PORT_BITS) begin
      pbit = PORT_BITS'(1) << req_q.port;
    end
    unique case (req_q.cmd)
      mcgt_pkg::CMD_JOIN:  upd = mem_rd | pbit;
      mcgt_pkg::CMD_LEAVE: upd = mem_rd & ~pbit;
      default:             upd = mem_rd;
    endcase
    match     = pend && (addr_rd == req_q.group_addr);
    at_end    = idx >= fill;
    hit_now   = (state == S_SCAN) && match;
    miss_now  = (state == S_SCAN) && !match && at_end;
    room      = fill < CW'(MAX_GROUPS);
    app       = miss_now && (req_q.cmd == mcgt_pkg::CMD_JOIN) && room;
    mem_we    = hit_now || app;
    mem_waddr = hit_now ? pidx : fill[AW-1:0];
    mem_wdata = hit_now ? upd : pbit;
    upd_ext   = EXT_W'(upd);
    pbit_ext  = EXT_W'(pbit);
  end

  mcgt_ram #(
    .WIDTH (mcgt_pkg::ADDR_W),
    .DEPTH (MAX_GROUPS)
  ) u_addr_ram (
    .clk   (clk),
    .we    (app),
    .waddr (fill[AW-1:0]),
    .wdata (req_q.group_addr),
    .raddr (idx[AW-1:0]),
    .rdata (addr_rd)
  );

  mcgt_ram #(
    .WIDTH (PORT_BITS),
    .DEPTH (MAX_GROUPS)
  ) u_member_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (mem_rd)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      fill  <= '0;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            idx   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_now) begin
            done                 <= 1'b1;
            result.member_bitmap <= upd_ext[mcgt_pkg::BITMAP_W-1:0];
            result.hit           <= 1'b1;
            result.full_drop     <= 1'b0;
            state                <= S_IDLE;
          end else if (miss_now) begin
            done                 <= 1'b1;
            result.member_bitmap <= app ? pbit_ext[mcgt_pkg::BITMAP_W-1:0] : '0;
            result.hit           <= 1'b0;
            result.full_drop     <= (req_q.cmd == mcgt_pkg::CMD_JOIN) && !room;
            if (app) begin
              fill <= fill + 1'b1;
            end
            state <= S_IDLE;
          end else begin
            pend <= 1'b1;
            pidx <= idx[AW-1:0];
            idx  <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/mcgt_chk.sv @@
// Port-level checker for the multicast group member table, bound to the top.
// Depends on mcgt_pkg and multicast_group_member_table_top.
module mcgt_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input mcgt_pkg::in_t  req,
  input logic           done,
  input mcgt_pkg::out_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted but busy did not rise");

  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in progress");

  a_hit_drop: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.hit && result.full_drop))
    else $error("hit and full_drop together");

  a_drop_empty: assert property (@(posedge clk) disable iff (rst)
    (done && result.full_drop) |-> (result.member_bitmap == '0))
    else $error("dropped join with nonzero bitmap");

endmodule

bind multicast_group_member_table_top mcgt_chk u_mcgt_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .req    (req),
  .done   (done),
  .result (result)
);
